[sv/source_knock_count_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the source knock count table
// Each macro checks one clocked property. The checks are left out when SYNTH
// is defined.
// ----------------------------------------------------------------------------
`ifndef SOURCE_KNOCK_COUNT_TABLE_ASSERT_SVH
`define SOURCE_KNOCK_COUNT_TABLE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define SKCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
// Next-cycle implication.
`define SKCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define SKCT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SKCT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/skct_pkg.sv]
// ----------------------------------------------------------------------------
// Source knock count table package
// Shared sizes, codes and types of the source knock count table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skct_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int MODE_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 8;
  localparam int STAMP_W  = 32;
  localparam int TMO_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [MODE_W-1:0] MODE_PKT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SWEEP = 2'd2;

  localparam logic [KIND_W-1:0] KIND_RECORDED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PASSED   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK   = 2'd1;

  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd10;
  localparam logic [COUNT_W-1:0] KNOCK_RST   = 8'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PKT   = 4'b0010,
    S_SWEEP = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

[sv/source_knock_count_table.sv]
// ----------------------------------------------------------------------------
// Source knock count table
// Counts packets per source address in a small table and reports, at each
// expiry sweep, the expiring sources whose count equals the knock count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Usage: pulse start with in_mode while busy is low. A packet (mode 0) gives
// exactly one result, kind 0 (recorded) or kind 1 (table full), with
// out_last set. A tick (mode 1) gives no result and never raises busy. A
// sweep (mode 2) gives one kind 2 result per expiring entry whose count
// equals knock_count, in slot order, then one kind 3 result with out_last
// set. Mode 3 is ignored. Each result is on the out_ ports for exactly one
// cycle under out_valid; the receiver cannot stall the block.
// Timing: the entries sit in a table memory with one write port and a
// registered read port; the scan reads one slot per cycle and compares the
// slot read in the previous cycle. A packet ends at the slot that it hits,
// or after the last slot on a miss; a sweep ends with its kind 3 result.
// The next item can be accepted once busy falls, so the block takes no new
// item while a packet or sweep is still open. Configuration writes are
// taken while the block is idle.

module source_knock_count_table (
  input  logic                            clk,
  input  logic                            rst_n,
  // Item input
  input  logic                            start,
  output logic                            busy,
  input  logic [skct_pkg::MODE_W-1:0]     in_mode,
  input  logic [skct_pkg::ADDR_W-1:0]     in_src_addr,
  // Results
  output logic                            out_valid,
  output logic [skct_pkg::KIND_W-1:0]     out_kind,
  output logic [skct_pkg::ADDR_W-1:0]     out_addr_out,
  output logic                            out_last,
  // Configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [skct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skct_pkg::CFG_DAT_W-1:0]  cfg_data
);

  import skct_pkg::*;

  // Configuration and time base.
  logic [TMO_W-1:0]   timeout_r;
  logic [COUNT_W-1:0] knock_r;
  logic [STAMP_W-1:0] seconds_r;

  // Control.
  state_t             state_r, state_nxt;
  logic               accept;
  logic [CNT_W-1:0]   scan_idx_r;   // next slot to read
  logic               cmp_vld_r;    // read data for cmp_idx_r is present
  logic [IDX_W-1:0]   cmp_idx_r;    // slot whose data sits in rd_data_r
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [ADDR_W-1:0]  key_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  // Table memory.
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data_r;
  logic [IDX_W-1:0]   rd_idx;
  logic               mem_we;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             wr_data;

  // Compare stage.
  logic               issue;
  logic               last_cmp;
  logic               slot_valid;
  logic               hit;
  logic               expire;
  logic               pass;
  logic               free_any;
  logic [IDX_W-1:0]   free_sel;
  logic [STAMP_W-1:0] idle_time;

  // Result register.
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic               out_last_r;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign accept    = start && !busy;

  assign issue    = (state_r == S_PKT || state_r == S_SWEEP) &&
                    (scan_idx_r < CNT_W'(TABLE_DEPTH));
  assign rd_idx   = scan_idx_r[IDX_W-1:0];
  assign last_cmp = cmp_idx_r == IDX_W'(TABLE_DEPTH - 1);

  assign slot_valid = valid_r[cmp_idx_r];
  assign idle_time  = seconds_r - rd_data_r.stamp;
  assign hit    = cmp_vld_r && (state_r == S_PKT) && slot_valid &&
                  (rd_data_r.addr == key_r);
  assign expire = cmp_vld_r && (state_r == S_SWEEP) && slot_valid &&
                  (idle_time > STAMP_W'(timeout_r));
  assign pass   = expire && (rd_data_r.count == knock_r);
  assign free_any = free_found_r || !slot_valid;
  assign free_sel = free_found_r ? free_idx_r : cmp_idx_r;

  // The only memory write closes a packet, and the state goes idle at the
  // same edge, so no read of that slot can be in flight.
  always_comb begin
    mem_we  = 1'b0;
    wr_idx  = cmp_idx_r;
    wr_data = rd_data_r;
    if (hit) begin
      mem_we        = 1'b1;
      wr_data.count = (rd_data_r.count == COUNT_MAX) ? COUNT_MAX
                                                     : rd_data_r.count + 1'b1;
      wr_data.stamp = seconds_r;
    end else if (cmp_vld_r && state_r == S_PKT && last_cmp && free_any) begin
      mem_we        = 1'b1;
      wr_idx        = free_sel;
      wr_data.addr  = key_r;
      wr_data.count = COUNT_W'(1);
      wr_data.stamp = seconds_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_PKT) begin
          state_nxt = S_PKT;
        end else if (accept && in_mode == MODE_SWEEP) begin
          state_nxt = S_SWEEP;
        end
      end
      S_PKT: begin
        if (hit || (cmp_vld_r && last_cmp)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (cmp_vld_r && last_cmp) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      timeout_r    <= TIMEOUT_RST;
      knock_r      <= KNOCK_RST;
      seconds_r    <= '0;
      valid_r      <= '0;
      scan_idx_r   <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_TIMEOUT: timeout_r <= cfg_data;
          REG_KNOCK:   knock_r   <= cfg_data[COUNT_W-1:0];
          default:     ;
        endcase
      end

      if (accept && in_mode == MODE_TICK) begin
        seconds_r <= seconds_r + 1'b1;
      end

      if (accept) begin
        scan_idx_r   <= '0;
        free_found_r <= 1'b0;
      end

      // Keep the scan pipeline running only while the item is still open.
      if (issue && state_nxt == state_r) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        cmp_idx_r  <= rd_idx;
        cmp_vld_r  <= 1'b1;
      end else begin
        cmp_vld_r  <= 1'b0;
      end

      if (cmp_vld_r && state_r == S_PKT && !slot_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end

      if (mem_we && !hit) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (expire) begin
        valid_r[cmp_idx_r] <= 1'b0;
      end

      // Results.
      if (hit) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_RECORDED;
        out_addr_r  <= key_r;
        out_last_r  <= 1'b1;
      end else if (cmp_vld_r && state_r == S_PKT && last_cmp) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= free_any ? KIND_RECORDED : KIND_FULL;
        out_addr_r  <= key_r;
        out_last_r  <= 1'b1;
      end else if (pass) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_PASSED;
        out_addr_r  <= rd_data_r.addr;
        out_last_r  <= 1'b0;
      end else if (state_r == S_DONE) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= KIND_DONE;
        out_addr_r  <= '0;
        out_last_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_src_addr;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_addr_out = out_addr_r;
  assign out_last     = out_last_r;

  // Checks.
  `include "source_knock_count_table_assert.svh"

  `SKCT_ASSERT_NEXT(a_quiet_after_last, clk, rst_n, out_valid && out_last, !out_valid)
  `SKCT_ASSERT_NEXT(a_busy_after_start, clk, rst_n, accept && (in_mode == MODE_PKT || in_mode == MODE_SWEEP), busy)
  `SKCT_ASSERT_IMPLY(a_idle_no_compare, clk, rst_n, state_r == S_IDLE, !cmp_vld_r)
  `SKCT_ASSERT_NEXT(a_write_closes_item, clk, rst_n, mem_we, !busy && out_valid && out_last)

endmodule

[tb/skct_checker.sv]
// ----------------------------------------------------------------------------
// Source knock count table checker
// Watches the item, result and register channels of the table, keeps its own
// copy of the table and registers, and compares every result with the oldest
// expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skct_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [skct_pkg::MODE_W-1:0]     in_mode,
  input  logic [skct_pkg::ADDR_W-1:0]     in_src_addr,
  input  logic                            out_valid,
  input  logic [skct_pkg::KIND_W-1:0]     out_kind,
  input  logic [skct_pkg::ADDR_W-1:0]     out_addr_out,
  input  logic                            out_last,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [skct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skct_pkg::CFG_DAT_W-1:0]  cfg_data,
  output int unsigned                     fail_count,
  output int unsigned                     pending_results
);

  import skct_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } knock_result_t;

  knock_result_t result_queue[$];
  knock_result_t want;
  int unsigned   fails = 0;

  // Shadow table and registers.
  logic               slot_live  [TABLE_DEPTH];
  logic [ADDR_W-1:0]  slot_addr  [TABLE_DEPTH];
  logic [COUNT_W-1:0] slot_count [TABLE_DEPTH];
  logic [STAMP_W-1:0] slot_stamp [TABLE_DEPTH];
  logic [STAMP_W-1:0] now_sec;
  logic [TMO_W-1:0]   timeout_reg;
  logic [COUNT_W-1:0] knock_reg;

  function automatic knock_result_t result_of(input logic [KIND_W-1:0] kind,
                                              input logic [ADDR_W-1:0] addr,
                                              input logic last);
    knock_result_t r;
    r.kind = kind;
    r.addr = addr;
    r.last = last;
    return r;
  endfunction

  task automatic clear_table();
    int slot;
    for (slot = 0; slot < TABLE_DEPTH; slot++) begin
      slot_live[slot]  = 1'b0;
      slot_addr[slot]  = '0;
      slot_count[slot] = '0;
      slot_stamp[slot] = '0;
    end
    now_sec     = '0;
    timeout_reg = TIMEOUT_RST;
    knock_reg   = KNOCK_RST;
  endtask

  task automatic count_packet(input logic [ADDR_W-1:0] addr);
    int slot;
    int free_slot;
    bit hit;
    free_slot = -1;
    hit       = 1'b0;
    for (slot = 0; slot < TABLE_DEPTH; slot++) begin
      if (!hit) begin
        if (slot_live[slot] && slot_addr[slot] == addr) begin
          if (slot_count[slot] != COUNT_MAX) slot_count[slot] = slot_count[slot] + 1'b1;
          slot_stamp[slot] = now_sec;
          hit = 1'b1;
        end else if (!slot_live[slot] && free_slot < 0) begin
          free_slot = slot;
        end
      end
    end
    if (hit) begin
      result_queue.push_back(result_of(KIND_RECORDED, addr, 1'b1));
    end else if (free_slot < 0) begin
      result_queue.push_back(result_of(KIND_FULL, addr, 1'b1));
    end else begin
      slot_live[free_slot]  = 1'b1;
      slot_addr[free_slot]  = addr;
      slot_count[free_slot] = 8'd1;
      slot_stamp[free_slot] = now_sec;
      result_queue.push_back(result_of(KIND_RECORDED, addr, 1'b1));
    end
  endtask

  task automatic expire_entries();
    int slot;
    logic [STAMP_W-1:0] idle;
    for (slot = 0; slot < TABLE_DEPTH; slot++) begin
      if (slot_live[slot]) begin
        idle = now_sec - slot_stamp[slot];
        if (idle > {{(STAMP_W-TMO_W){1'b0}}, timeout_reg}) begin
          if (slot_count[slot] == knock_reg)
            result_queue.push_back(result_of(KIND_PASSED, slot_addr[slot], 1'b0));
          slot_live[slot] = 1'b0;
        end
      end
    end
    result_queue.push_back(result_of(KIND_DONE, '0, 1'b1));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      result_queue.delete();
    end else begin
      // Results first: one that ends now belongs to an item accepted earlier.
      if (out_valid) begin
        if (result_queue.size() == 0) begin
          $error("result with no item waiting: kind %0d addr %h last %0d",
                 out_kind, out_addr_out, out_last);
          fails++;
        end else begin
          want = result_queue.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", want.kind, out_kind);
            fails++;
          end
          if (out_addr_out !== want.addr) begin
            $error("addr_out mismatch: expected %h, actual %h", want.addr, out_addr_out);
            fails++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_last);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_reg = cfg_data[TMO_W-1:0];
          REG_KNOCK:   knock_reg   = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_mode)
          MODE_PKT:   count_packet(in_src_addr);
          MODE_TICK:  now_sec = now_sec + 1'b1;
          MODE_SWEEP: expire_entries();
          default: ;
        endcase
      end
    end
    fail_count      <= fails;
    pending_results <= result_queue.size();
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Source knock count table testbench
// Drives packets, ticks and sweeps into the table under several register
// settings and idle patterns; a checker beside the block predicts and compares
// every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import skct_pkg::*;

  // Codes the package leaves unnamed: the unused mode and the register
  // indexes past the end of the register list.
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int POOL_SIZE = 24;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  logic [MODE_W-1:0]    in_mode     = '0;
  logic [ADDR_W-1:0]    in_src_addr = '0;
  logic                 out_valid;
  logic [KIND_W-1:0]    out_kind;
  logic [ADDR_W-1:0]    out_addr_out;
  logic                 out_last;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DAT_W-1:0] cfg_data    = '0;
  int unsigned          fail_count;
  int unsigned          pending_results;

  // Percentage of items preceded by a sender gap, set per phase.
  int                   idle_pct    = 0;
  int                   items_sent  = 0;
  logic [ADDR_W-1:0]    addr_pool [POOL_SIZE];

  source_knock_count_table dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_src_addr  (in_src_addr),
    .out_valid    (out_valid),
    .out_kind     (out_kind),
    .out_addr_out (out_addr_out),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  skct_checker skct_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_src_addr     (in_src_addr),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_addr_out    (out_addr_out),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The slowest correct run is well under a tenth of this.
  initial begin
    #10_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Presents one item at a falling edge, optionally after a gap, and returns
  // at the rising edge where the block takes it. Start stays high when the
  // next item follows without a gap, so it is never lowered and raised in the
  // same step.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_mode     <= mode;
    in_src_addr <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Stops sending and waits for every expected result. The checker's count is
  // registered, so the first look comes at the edge after the last item.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Drains, then lets a tick or an ignored item finish its cycle before a
  // register changes.
  task automatic settle_block();
    drain_results();
    repeat (TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic tick_run(input int count);
    int i;
    for (i = 0; i < count; i++) send_item(MODE_TICK, $urandom);
  endtask

  // Sends distinct addresses until the table must be full, plus one more
  // that has to be dropped.
  task automatic fill_table();
    int i;
    for (i = 0; i <= TABLE_DEPTH; i++) begin
      send_item(MODE_PKT, {16'($urandom_range(0, 65535)), i[15:0]});
    end
  endtask

  // A knock from one pooled source: usually exactly the knock count, with the
  // odd tick in between so the stamps differ.
  task automatic knock_run(input int knock);
    logic [ADDR_W-1:0] addr;
    int n;
    int i;
    addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (knock == 0) n = $urandom_range(1, 4);
    else if ($urandom_range(0, 99) < 70) n = knock;
    else n = $urandom_range(1, knock + 2);
    for (i = 0; i < n; i++) begin
      send_item(MODE_PKT, addr);
      if ($urandom_range(0, 99) < 20) send_item(MODE_TICK, $urandom);
    end
  endtask

  // Mostly well-formed knock traffic with aging and sweeps, some noise.
  task automatic random_phase(input int count, input int knock, input int timeout);
    int goal;
    int pick;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) knock_run(knock);
      else if (pick < 70) tick_run($urandom_range(1, timeout + 2));
      else if (pick < 85) send_item(MODE_SWEEP, $urandom);
      else if (pick < 92) send_item(MODE_PKT, $urandom);
      else if (pick < 96) send_item(MODE_UNUSED, $urandom);
      else drain_results();
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] hot_addr;
    logic [ADDR_W-1:0] side_addr;
    int i;
    int knock;
    int timeout;

    for (i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    addr_pool[0] = '0;
    addr_pool[1] = '1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings (timeout 10, knock 3): a sweep
    // of the empty table, the address extremes, hits, the unused mode, and an
    // entry aged just past the timeout while another one is refreshed.
    send_item(MODE_SWEEP, '1);
    send_item(MODE_PKT, '0);
    send_item(MODE_PKT, '1);
    send_item(MODE_PKT, '0);
    send_item(MODE_PKT, '0);
    send_item(MODE_UNUSED, 32'hA5A5_A5A5);
    send_item(MODE_SWEEP, '0);
    tick_run(11);
    send_item(MODE_PKT, '1);
    send_item(MODE_SWEEP, '0);

    // Lowest settings: everything aged by one tick expires, and each entry
    // seen once passes, so a full table gives the longest sweep.
    settle_block();
    write_register(REG_TIMEOUT, 16'h0000);
    write_register(REG_KNOCK, 16'h0001);
    fill_table();
    send_item(MODE_TICK, '0);
    send_item(MODE_SWEEP, '0);
    random_phase(16, 1, 0);

    // Still at timeout zero, one tick and a sweep empty the table. Then, at
    // the highest settings, one source is hammered past count saturation;
    // nothing ages out under the longest timeout, and the saturated entry
    // passes once the timeout is lowered to just below its idle time.
    send_item(MODE_TICK, '0);
    send_item(MODE_SWEEP, '0);
    settle_block();
    write_register(REG_TIMEOUT, 16'hFFFF);
    write_register(REG_KNOCK, 16'h00FF);
    hot_addr  = $urandom;
    side_addr = ~hot_addr;
    for (i = 0; i < 258; i++) begin
      send_item(MODE_PKT, hot_addr);
      if (i % 100 == 0) send_item(MODE_PKT, side_addr);
    end
    tick_run(3);
    send_item(MODE_SWEEP, '0);
    settle_block();
    write_register(REG_TIMEOUT, 16'h0003);
    send_item(MODE_SWEEP, '0);
    send_item(MODE_TICK, '0);
    send_item(MODE_SWEEP, '0);

    // Knock count zero, written with the upper data bits set: expired
    // entries are freed but none can pass. The sender idles often.
    settle_block();
    write_register(REG_KNOCK, 16'hFF00);
    write_register(REG_TIMEOUT, 16'h0005);
    idle_pct = 61;
    random_phase(16, 0, 5);

    // Writes past the register list must change nothing.
    settle_block();
    knock   = $urandom_range(1, 5);
    timeout = $urandom_range(1, 20);
    write_register(REG_SPARE_2, 16'($urandom));
    write_register(REG_SPARE_3, 16'hFFFF);
    write_register(REG_TIMEOUT, timeout[CFG_DAT_W-1:0]);
    write_register(REG_KNOCK, knock[CFG_DAT_W-1:0]);
    idle_pct = 8;
    random_phase(20, knock, timeout);

    settle_block();
    knock   = $urandom_range(2, 4);
    timeout = $urandom_range(2, 12);
    write_register(REG_TIMEOUT, timeout[CFG_DAT_W-1:0]);
    write_register(REG_KNOCK, knock[CFG_DAT_W-1:0]);
    idle_pct = 61;
    random_phase(16, knock, timeout);

    drain_results();
    repeat (2 * TABLE_DEPTH + 4) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
